>>> rtl/sacl_pkg.sv
// shared constants, types and state encoding for the cache tag block
`default_nettype none
package sacl_pkg;

    localparam int WAYS         = 4;
    localparam int MAX_SET_BITS = 6;
    localparam int AGE_WIDTH    = 16;

    localparam int ADDR_W   = 64;
    localparam int TAG_W    = 64;
    localparam int WAY_OUT_W = 3;
    localparam int CNT_W    = 32;
    localparam int SETB_W   = 3;
    localparam int BLKB_W   = 5;
    localparam int CFG_W    = 5;
    localparam int CFG_IDX_W = 1;
    localparam int SHAMT_W  = 6;

    localparam int NUM_SETS = 1 << MAX_SET_BITS;
    localparam int SET_W    = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
    localparam int WAY_W    = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int ENT_W    = TAG_W + AGE_WIDTH;
    localparam int ROW_W    = WAYS * ENT_W;

    localparam logic [AGE_WIDTH-1:0] AGE_MAX = '1;
    localparam logic [CNT_W-1:0]     CNT_MAX = '1;

    localparam logic [CFG_IDX_W-1:0] REG_SET_BITS   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BLOCK_BITS = 1'd1;

    typedef enum logic [0:0] {
        S_IDLE,
        S_LOOKUP
    } t_state;

    typedef struct packed {
        logic capture;
        logic commit;
    } t_cmd;

endpackage
`default_nettype wire

>>> rtl/sacl_in_if.sv
// access channel: one address per transfer
`default_nettype none
interface sacl_in_if import sacl_pkg::*;;
    logic              valid;
    logic              ready;
    logic [ADDR_W-1:0] address;

    modport source (output valid, output address, input ready);
    modport sink   (input valid, input address, output ready);
endinterface
`default_nettype wire

>>> rtl/sacl_out_if.sv
// result channel: hit flag, way and running counters per transfer
`default_nettype none
interface sacl_out_if import sacl_pkg::*;;
    logic                 valid;
    logic                 ready;
    logic                 hit;
    logic [WAY_OUT_W-1:0] way_used;
    logic [CNT_W-1:0]     hit_count;
    logic [CNT_W-1:0]     miss_count;

    modport source (output valid, output hit, output way_used, output hit_count,
                     output miss_count, input ready);
    modport sink   (input valid, input hit, input way_used, input hit_count,
                     input miss_count, output ready);
endinterface
`default_nettype wire

>>> rtl/sacl_ctrl.sv
// controller: sequences lookup and commit of one access at a time
`default_nettype none
module sacl_ctrl import sacl_pkg::*; (
    input  wire  i_clk,
    input  wire  i_rst_n,
    input  wire  i_in_valid,
    output logic o_in_ready,
    input  wire  i_out_ready,
    output logic o_out_valid,
    output t_cmd o_cmd
);

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   out_free;

    assign out_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_LOOKUP;
                end
            end
            S_LOOKUP: begin
                if (out_free) begin
                    n_state     = S_IDLE;
                    n_out_valid = 1'b1;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready    = 1'b0;
        o_cmd.capture = 1'b0;
        o_cmd.commit  = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready    = 1'b1;
                o_cmd.capture = i_in_valid;
            end
            S_LOOKUP: begin
                o_cmd.commit = out_free;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

    assign o_out_valid = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule
`default_nettype wire

>>> rtl/sacl_dpath.sv
// datapath: config, tag/age memory, valid bits, way select, counters, result register
`default_nettype none
module sacl_dpath import sacl_pkg::*; (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  t_cmd                  i_cmd,
    input  wire  [ADDR_W-1:0]     i_address,
    input  wire                   i_cfg_we,
    input  wire  [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire  [CFG_W-1:0]      i_cfg_data,
    output logic                  o_hit,
    output logic [WAY_OUT_W-1:0]  o_way_used,
    output logic [CNT_W-1:0]      o_hit_count,
    output logic [CNT_W-1:0]      o_miss_count
);

    logic [SETB_W-1:0]  r_set_bits;
    logic [BLKB_W-1:0]  r_block_bits;

    logic [ROW_W-1:0]   mem [NUM_SETS];
    logic [WAYS-1:0]    r_valid [NUM_SETS];

    logic [ROW_W-1:0]   r_rdata;
    logic [WAYS-1:0]    r_vrow;
    logic [TAG_W-1:0]   r_tag;
    logic [SET_W-1:0]   r_set;
    logic [CNT_W-1:0]   r_hits, r_misses;

    logic [SHAMT_W-1:0] s_eff;
    logic [SHAMT_W-1:0] tag_shamt;
    logic [ADDR_W-1:0]  set_mask, set_full;
    logic [SET_W-1:0]   in_set;
    logic [TAG_W-1:0]   in_tag;

    logic [TAG_W-1:0]     way_tag [WAYS];
    logic [AGE_WIDTH-1:0] way_age [WAYS];
    logic [WAYS-1:0]      hit_vec;
    logic                 hit;
    logic                 any_free;
    logic [WAY_W-1:0]     hit_way, free_way, lru_way, sel_way;
    logic [AGE_WIDTH-1:0] age_tmp;
    logic [ROW_W-1:0]     wrow;
    logic [CNT_W-1:0]     n_hits, n_misses;

    // address split
    always_comb begin
        s_eff     = (SHAMT_W'(r_set_bits) > SHAMT_W'(MAX_SET_BITS)) ?
                    SHAMT_W'(MAX_SET_BITS) : SHAMT_W'(r_set_bits);
        tag_shamt = s_eff + SHAMT_W'(r_block_bits);
        in_tag    = i_address >> tag_shamt;
        set_mask  = ~({ADDR_W{1'b1}} << s_eff);
        set_full  = (i_address >> r_block_bits) & set_mask;
        in_set    = set_full[SET_W-1:0];
    end

    // way search and age update
    always_comb begin
        hit      = 1'b0;
        hit_way  = '0;
        any_free = 1'b0;
        free_way = '0;
        lru_way  = '0;
        for (int w = 0; w < WAYS; w++) begin
            way_tag[w] = r_rdata[w*ENT_W +: TAG_W];
            way_age[w] = r_vrow[w] ? r_rdata[w*ENT_W+TAG_W +: AGE_WIDTH] : '0;
            hit_vec[w] = r_vrow[w] && (way_tag[w] == r_tag);
        end
        for (int w = WAYS-1; w >= 0; w--) begin
            if (hit_vec[w]) begin
                hit     = 1'b1;
                hit_way = WAY_W'(w);
            end
            if (!r_vrow[w]) begin
                any_free = 1'b1;
                free_way = WAY_W'(w);
            end
        end
        // oldest way, ties to the lowest index
        for (int w = 1; w < WAYS; w++) begin
            if (way_age[w] > way_age[lru_way]) begin
                lru_way = WAY_W'(w);
            end
        end
        sel_way = hit ? hit_way : (any_free ? free_way : lru_way);
        for (int w = 0; w < WAYS; w++) begin
            age_tmp = (sel_way == WAY_W'(w)) ? '0 : way_age[w];
            if (age_tmp != AGE_MAX) begin
                age_tmp = age_tmp + 1'b1;
            end
            wrow[w*ENT_W+TAG_W +: AGE_WIDTH] = age_tmp;
            wrow[w*ENT_W +: TAG_W] = (sel_way == WAY_W'(w)) ? r_tag : way_tag[w];
        end
        n_hits   = r_hits;
        n_misses = r_misses;
        if (hit) begin
            if (r_hits != CNT_MAX) n_hits = r_hits + 1'b1;
        end else begin
            if (r_misses != CNT_MAX) n_misses = r_misses + 1'b1;
        end
    end

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_set_bits   <= '0;
            r_block_bits <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_SET_BITS:   r_set_bits   <= i_cfg_data[SETB_W-1:0];
                REG_BLOCK_BITS: r_block_bits <= i_cfg_data[BLKB_W-1:0];
                default:        r_set_bits   <= r_set_bits;
            endcase
        end
    end

    // tag and age memory, one row per set
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            mem[r_set] <= wrow;
        end
        if (i_cmd.capture) begin
            r_rdata <= mem[in_set];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < NUM_SETS; s++) begin
                r_valid[s] <= '0;
            end
            r_hits   <= '0;
            r_misses <= '0;
        end else if (i_cmd.commit) begin
            r_valid[r_set][sel_way] <= 1'b1;
            r_hits   <= n_hits;
            r_misses <= n_misses;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_vrow <= r_valid[in_set];
            r_tag  <= in_tag;
            r_set  <= in_set;
        end
        if (i_cmd.commit) begin
            o_hit        <= hit;
            o_way_used   <= WAY_OUT_W'(sel_way);
            o_hit_count  <= n_hits;
            o_miss_count <= n_misses;
        end
    end

endmodule
`default_nettype wire

>>> rtl/set_assoc_cache_tag_lru.sv
// top level of the set-associative cache tag block with lru replacement
//
// i_acc carries one address per transfer (valid/ready). the block splits it
// into tag and set with the set_bits and block_bits registers, written on the
// plain port i_cfg_we / i_cfg_idx / i_cfg_data; the user must write them only
// while the block is idle, the block does not enforce it. o_res carries one
// result per access: hit flag, way that hit or was filled, and the saturating
// running hit and miss counts including this access. the transfer cycle reads
// the set's row from the tag/age memory into a register, the next cycle
// compares all ways, picks the way, writes the row back and loads the result
// register. the result is valid the cycle after that. a new access is taken in
// the cycle after the previous commit, not before, since the row memory is read
// through a single register and then written back. a stalled receiver holds
// the result register; one more access can be read meanwhile and waits in the
// compare cycle until the result register frees. synchronous reset clears all
// valid bits, the counters, the config registers and the control state at
// once; no clearing pass is needed.
`default_nettype none
module set_assoc_cache_tag_lru import sacl_pkg::*; (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    sacl_in_if.sink              i_acc,
    sacl_out_if.source           o_res,
    input  wire                  i_cfg_we,
    input  wire [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire [CFG_W-1:0]      i_cfg_data
);

    t_cmd cmd;

    sacl_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_acc.valid),
        .o_in_ready  (i_acc.ready),
        .i_out_ready (o_res.ready),
        .o_out_valid (o_res.valid),
        .o_cmd       (cmd)
    );

    sacl_dpath u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_address    (i_acc.address),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .o_hit        (o_res.hit),
        .o_way_used   (o_res.way_used),
        .o_hit_count  (o_res.hit_count),
        .o_miss_count (o_res.miss_count)
    );

endmodule
`default_nettype wire
